/* rtl/assert_macros.svh */
// Assertion macros used by the tracker's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define TKL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen outside reset.
`define TKL_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TKL_ASSERT(lbl, clk, rstn, prop, msg)
`define TKL_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* rtl/tkl_pkg.sv */
// Package for the top-K tracker: widths, command codes and cell control.
package tkl_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 10;
  localparam int unsigned SIZE_BITS_DEF  = 48;
  localparam int unsigned TAG_BITS_DEF   = 16;
  localparam int unsigned RANK_BITS      = 4;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // place item or shift down from the neighbour above
    logic rot;   // rotate towards slot 0 for readout
  } cell_ctrl_t;

endpackage

/* rtl/tkl_intf.sv */
// Valid/ready channel interfaces for the tracker's input and result words.
interface tkl_in_if
  import tkl_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SIZE_BITS-1:0] item_size;
  logic [TAG_BITS-1:0]  item_tag;

  modport source (output valid, command, item_size, item_tag, input ready);
  modport sink   (input valid, command, item_size, item_tag, output ready);
endinterface

interface tkl_out_if
  import tkl_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [RANK_BITS-1:0] rank;
  logic [SIZE_BITS-1:0] entry_size;
  logic [TAG_BITS-1:0]  entry_tag;
  logic                 inserted;
  logic                 last;

  modport source (output valid, rank, entry_size, entry_tag, inserted, last,
                  input ready);
  modport sink   (input valid, rank, entry_size, entry_tag, inserted, last,
                  output ready);
endinterface

/* rtl/tkl_cell.sv */
// One slot of the sorted list: compares, takes new word or a neighbour's.
module tkl_cell
  import tkl_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [SIZE_BITS-1:0] item_size_i,
  input  logic [TAG_BITS-1:0]  item_tag_i,
  input  logic                 prev_gt_i,   // slot above also beaten
  input  logic [SIZE_BITS-1:0] up_size_i,
  input  logic [TAG_BITS-1:0]  up_tag_i,
  input  logic [SIZE_BITS-1:0] dn_size_i,
  input  logic [TAG_BITS-1:0]  dn_tag_i,
  output logic                 gt_o,
  output logic [SIZE_BITS-1:0] size_o,
  output logic [TAG_BITS-1:0]  tag_o
);

  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic                 gt;

  assign gt = item_size_i > size_q;

  always_comb begin
    size_d = size_q;
    tag_d  = tag_q;
    if (ctrl_i.rot) begin
      size_d = dn_size_i;
      tag_d  = dn_tag_i;
    end else if (ctrl_i.ins && gt) begin
      // list is descending, so the first beaten slot takes the item
      if (prev_gt_i) begin
        size_d = up_size_i;
        tag_d  = up_tag_i;
      end else begin
        size_d = item_size_i;
        tag_d  = item_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      tag_q  <= '0;
    end else begin
      size_q <= size_d;
      tag_q  <= tag_d;
    end
  end

  assign gt_o   = gt;
  assign size_o = size_q;
  assign tag_o  = tag_q;

endmodule

/* rtl/top_k_largest_tracker_unit.sv */
// Top level of the top-K tracker: cell chain, readout sequencer, output register.
//
//  channel | dir | word                               | handshake
//  in_i    | in  | command, item_size, item_tag       | valid/ready
//  out_o   | out | rank, entry_size, entry_tag,       | valid/ready
//          |     | inserted, last                     |
//
// On an insert all slots compare in parallel and shift together, so inserts may
// follow each other every cycle while the output is free and no readout runs.
// A readout rotates the chain one slot towards slot 0 per result word, and
// input is held off until the list is back in place. After reset every slot
// holds zero. A stalled output holds the register in front of it, and with it
// input and rotation; a word may still be accepted when the output is taken.
module top_k_largest_tracker_unit
  import tkl_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF,
  parameter int unsigned TAG_BITS   = TAG_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tkl_in_if.sink    in_i,
  tkl_out_if.source out_o
);

  `include "assert_macros.svh"

  localparam int unsigned CW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned RW = $clog2(LIST_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_DUMP} state_e;

  state_e               state_q;
  logic [CW-1:0]        cnt_q;
  logic                 ov_q;
  logic [RANK_BITS-1:0] rank_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic                 ins_q;
  logic                 last_q;

  logic                 in_fire, out_free, step, dump_last, load;
  cell_ctrl_t           ctrl;
  logic [LIST_DEPTH-1:0] gt;
  logic [SIZE_BITS-1:0] c_size [LIST_DEPTH];
  logic [TAG_BITS-1:0]  c_tag  [LIST_DEPTH];
  logic [RW-1:0]        ins_rank;

  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign step       = (state_q == ST_DUMP) && out_free;
  assign dump_last  = cnt_q == CW'(LIST_DEPTH - 1);

  assign ctrl.ins = in_fire && (in_i.command == CMD_INSERT);
  assign ctrl.rot = step;

  // a new result word enters the output register
  assign load = ctrl.ins || step;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic                 prev_gt;
    logic [SIZE_BITS-1:0] up_size, dn_size;
    logic [TAG_BITS-1:0]  up_tag, dn_tag;

    if (i == 0) begin : g_head
      assign prev_gt = 1'b0;
      assign up_size = '0;
      assign up_tag  = '0;
    end else begin : g_body
      assign prev_gt = gt[i-1];
      assign up_size = c_size[i-1];
      assign up_tag  = c_tag[i-1];
    end
    // readout ring: the tail wraps to the head's word
    assign dn_size = c_size[(i + 1) % LIST_DEPTH];
    assign dn_tag  = c_tag[(i + 1) % LIST_DEPTH];

    tkl_cell #(
      .SIZE_BITS(SIZE_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .item_size_i(in_i.item_size),
      .item_tag_i (in_i.item_tag),
      .prev_gt_i  (prev_gt),
      .up_size_i  (up_size),
      .up_tag_i   (up_tag),
      .dn_size_i  (dn_size),
      .dn_tag_i   (dn_tag),
      .gt_o       (gt[i]),
      .size_o     (c_size[i]),
      .tag_o      (c_tag[i])
    );
  end

  // beaten slots form a tail, so the insert slot is the count of the others
  always_comb begin
    ins_rank = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ins_rank = ins_rank + RW'(!gt[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      rank_q  <= '0;
      size_q  <= '0;
      tag_q   <= '0;
      ins_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.command == CMD_READOUT) begin
              state_q <= ST_DUMP;
              cnt_q   <= '0;
            end else begin
              ins_q  <= gt[LIST_DEPTH-1];
              rank_q <= gt[LIST_DEPTH-1] ? RANK_BITS'(ins_rank) : '0;
              size_q <= in_i.item_size;
              tag_q  <= in_i.item_tag;
              last_q <= 1'b1;
            end
          end
        end
        ST_DUMP: begin
          if (step) begin
            ins_q  <= 1'b0;
            rank_q <= RANK_BITS'(cnt_q);
            size_q <= c_size[0];
            tag_q  <= c_tag[0];
            last_q <= dump_last;
            cnt_q  <= cnt_q + CW'(1);
            if (dump_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.rank       = rank_q;
  assign out_o.entry_size = size_q;
  assign out_o.entry_tag  = tag_q;
  assign out_o.inserted   = ins_q;
  assign out_o.last       = last_q;

  // list stays in descending order whenever it is not mid-rotation
  for (genvar i = 0; i + 1 < LIST_DEPTH; i++) begin : g_chk
    `TKL_ASSERT(a_sorted, clk_i, rst_ni, (state_q == ST_IDLE) |-> (c_size[i] >= c_size[i+1]), "list out of order")
  end

  `TKL_NEVER(a_ins_not_last, clk_i, rst_ni, ov_q && ins_q && !last_q, "insert word without last")
  `TKL_ASSERT(a_ins_result, clk_i, rst_ni, ctrl.ins |=> (ov_q && last_q && !(state_q == ST_DUMP)), "insert gave no word")
  `TKL_ASSERT(a_dump_end, clk_i, rst_ni, (step && dump_last) |=> (state_q == ST_IDLE && ov_q && last_q), "readout did not end on last")

endmodule
